// ----- design/fractional_feedback_delay_line_assert.svh -----
// Assertion macros shared by the delay line RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FRACTIONAL_FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FRACTIONAL_FEEDBACK_DELAY_LINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFDL_CHECK(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFDL_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ffdl_pkg.sv -----
// Shared types, widths, register indexes and helpers of the delay line.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package ffdl_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DELAY_W    = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  function automatic sample_t sat_sample(input logic signed [18:0] v);
    sample_t r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- design/fractional_feedback_delay_line.sv -----
// Top level of the multi-channel fractional feedback delay line.
// Depends on ffdl_pkg, ffdl_delay_mod, ffdl_ring_mem and the assertion header.
`timescale 1ns / 1ps
`include "fractional_feedback_delay_line_assert.svh"

// Usage:
// The slave stream takes one word per sample: tdata is the signed sample,
// tuser the channel number. The master stream returns one word per input:
// the dry sample plus the interpolated delayed sample, saturated.
// The configuration channel writes delay_samples (index 0, 8 fraction bits)
// and feedback_gain (index 1, Q1.15). Writes are taken in every cycle.
// A delay write starts a modulo reduction by a constant reciprocal, first
// the quotient, then the remainder; no sample is accepted until it is done.
// An accepted word passes the read and interpolate stage, and its result
// is then valid in the output register. The input is held off while that
// stage holds a word, so no new word is taken before the last has left it.
// The read of the next word meets the previous write in the same cycle
// and is forwarded.
// Reset clears the write pointers and the fill marks, so every ring entry
// reads as zero until written; there is no clearing pass. The delay returns
// to 32768 samples and the gain to zero.
// When the receiver stalls, the result holds in the output register and the
// input is held off until that register frees.

module fractional_feedback_delay_line #(
  parameter int unsigned DELAY_DEPTH = 65536,
  parameter int unsigned CHANNELS    = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] in_sample
  input  logic                             s_axis_tuser,  // [0] channel_index
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] out_sample
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffdl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ffdl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ffdl_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW = AW + FRAC_W;
  localparam int unsigned SW = PW + 1;
  localparam logic [SW-1:0] RING_V = SW'(DELAY_DEPTH * (2 ** FRAC_W));
  localparam logic [31:0] RING32 = 32'(DELAY_DEPTH * (2 ** FRAC_W));
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);

  logic                 in_acc, cfg_acc, delay_busy;
  logic [DELAY_W-1:0]   delay_mod;
  logic signed [GAIN_W-1:0] gain_q;

  logic [AW-1:0] wp_q [CHANNELS];
  logic [CHANNELS-1:0] wrap_q;

  logic [CW-1:0]  ch_in;
  logic [AW-1:0]  wp_sel, rd_i0, rd_i1;
  logic [SW-1:0]  pos_sum;
  logic [PW-1:0]  pos;
  logic           vld0, vld1, fwd0, fwd1;

  logic           s1_valid_q;
  logic [CW-1:0]  s1_ch_q;
  logic [AW-1:0]  s1_widx_q;
  sample_t        s1_x_q;
  logic [FRAC_W-1:0] s1_frac_q;
  logic           s1_vld0_q, s1_vld1_q, s1_fwd0_q, s1_fwd1_q;
  sample_t        fwd_data_q;

  sample_t        rd_data0, rd_data1, smp0, smp1, interp_d;
  logic signed [16:0] interp_diff;
  logic signed [25:0] interp_prod;
  logic signed [26:0] interp_acc;
  logic signed [18:0] out_sum;

  logic           s2_valid_q;
  logic [CW-1:0]  s2_ch_q;
  logic [AW-1:0]  s2_widx_q;
  sample_t        s2_x_q, s2_d_q;
  logic signed [31:0] fb_prod;
  logic signed [32:0] fb_round;
  logic signed [17:0] fb_term;
  logic signed [18:0] wr_sum;
  sample_t        wr_data;

  logic           out_valid_q;
  sample_t        out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  ffdl_delay_mod #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_delay_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_acc && (cfg_index_i == CFG_DELAY_SAMPLES)),
    .value_i(cfg_data_i[DELAY_W-1:0]),
    .busy_o (delay_busy),
    .delay_o(delay_mod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
    end else if (cfg_acc && (cfg_index_i == CFG_FEEDBACK_GAIN)) begin
      gain_q <= $signed(cfg_data_i[GAIN_W-1:0]);
    end
  end

  assign s_axis_tready = !delay_busy && !s1_valid_q && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    ch_in   = (CHANNELS > 1) ? CW'(s_axis_tuser) : '0;
    wp_sel  = wp_q[ch_in];
    pos_sum = {1'b0, wp_sel, {FRAC_W{1'b0}}} + RING_V - SW'(delay_mod);
    if (pos_sum >= RING_V) begin
      pos = PW'(pos_sum - RING_V);
    end else begin
      pos = pos_sum[PW-1:0];
    end
    rd_i0 = pos[PW-1:FRAC_W];
    rd_i1 = (rd_i0 == LAST_IDX) ? '0 : rd_i0 + 1'b1;
    vld0  = wrap_q[ch_in] || (rd_i0 < wp_sel);
    vld1  = wrap_q[ch_in] || (rd_i1 < wp_sel);
    fwd0  = s2_valid_q && (s2_ch_q == ch_in) && (s2_widx_q == rd_i0);
    fwd1  = s2_valid_q && (s2_ch_q == ch_in) && (s2_widx_q == rd_i1);
  end

  ffdl_ring_mem #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_ring_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s2_valid_q),
    .wr_ch_i   (s2_ch_q),
    .wr_idx_i  (s2_widx_q),
    .wr_data_i (wr_data),
    .rd_en_i   (in_acc),
    .rd_ch_i   (ch_in),
    .rd_idx0_i (rd_i0),
    .rd_idx1_i (rd_i1),
    .rd_data0_o(rd_data0),
    .rd_data1_o(rd_data1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c] <= '0;
      end
      wrap_q <= '0;
    end else if (in_acc) begin
      if (wp_sel == LAST_IDX) begin
        wp_q[ch_in]   <= '0;
        wrap_q[ch_in] <= 1'b1;
      end else begin
        wp_q[ch_in] <= wp_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q   <= ch_in;
      s1_widx_q <= wp_sel;
      s1_x_q    <= $signed(s_axis_tdata);
      s1_frac_q <= pos[FRAC_W-1:0];
      s1_vld0_q <= vld0;
      s1_vld1_q <= vld1;
      s1_fwd0_q <= fwd0;
      s1_fwd1_q <= fwd1;
    end
    if (s2_valid_q) begin
      fwd_data_q <= wr_data;
    end
    if (s1_valid_q) begin
      s2_ch_q   <= s1_ch_q;
      s2_widx_q <= s1_widx_q;
      s2_x_q    <= s1_x_q;
      s2_d_q    <= interp_d;
      out_q     <= sat_sample(out_sum);
    end
  end

  always_comb begin
    smp0 = !s1_vld0_q ? '0 : (s1_fwd0_q ? fwd_data_q : rd_data0);
    smp1 = !s1_vld1_q ? '0 : (s1_fwd1_q ? fwd_data_q : rd_data1);
    interp_diff = 17'(smp1) - 17'(smp0);
    interp_prod = $signed({1'b0, s1_frac_q}) * interp_diff;
    interp_acc  = $signed({{3{smp0[15]}}, smp0, {FRAC_W{1'b0}}}) + 27'(interp_prod)
                  + 27'sd128;
    interp_d    = interp_acc[23:8];
    out_sum     = 19'(s1_x_q) + 19'(interp_d);
  end

  always_comb begin
    fb_prod  = s2_d_q * gain_q;
    fb_round = 33'(fb_prod) + 33'sd16384;
    fb_term  = fb_round[32:15];
    wr_sum   = 19'(s2_x_q) + 19'(fb_term);
    wr_data  = sat_sample(wr_sum);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `FFDL_CHECK(a_stages_exclusive, clk_i, rst_ni, s2_valid_q, !s1_valid_q, "stage overlap")
  `FFDL_CHECK(a_fwd_only_valid, clk_i, rst_ni, s1_valid_q && s1_fwd0_q, s1_vld0_q, "fwd to empty")
  `FFDL_CHECK(a_delay_in_ring, clk_i, rst_ni, !delay_busy, 32'(delay_mod) < RING32, "delay range")
  `FFDL_CHECK_NEXT(a_result_loaded, clk_i, rst_ni, s1_valid_q, out_valid_q, "result lost")

endmodule

// ----- design/ffdl_delay_mod.sv -----
// Reduces a written delay value modulo the ring length in fraction units.
// The whole-sample part is divided by the ring depth through a constant reciprocal,
// quotient first and remainder after. Depends on ffdl_pkg.
`timescale 1ns / 1ps

module ffdl_delay_mod #(
  parameter int unsigned DELAY_DEPTH = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ffdl_pkg::DELAY_W-1:0]  value_i,
  output logic                          busy_o,
  output logic [ffdl_pkg::DELAY_W-1:0]  delay_o
);
  import ffdl_pkg::*;

  localparam int unsigned INT_W  = DELAY_W - FRAC_W;
  localparam int unsigned PROD_W = 2 * INT_W + 2;
  localparam int unsigned RING = DELAY_DEPTH * (2 ** FRAC_W);
  localparam logic [31:0] RING_V = 32'(RING);
  localparam logic [DELAY_W-1:0] RESET_MOD = DELAY_W'(32'(DELAY_RESET) % RING_V);
  localparam int unsigned SHIFT = INT_W + $clog2(DELAY_DEPTH);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH);
  localparam logic [INT_W+1:0] RECIP_V = RECIP[INT_W+1:0];
  localparam logic [31:0] DEPTH_V = 32'(DELAY_DEPTH);

  logic [INT_W-1:0]   whole_q, whole_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [INT_W-1:0]   quot_q, quot_d;
  logic [DELAY_W-1:0] rem_q, rem_d;
  logic               run_q, run_d;
  logic               fin_q, fin_d;
  logic [PROD_W-1:0]  quot_prod;
  logic [31:0]        back_prod;
  logic [INT_W-1:0]   whole_rem;

  always_comb begin
    quot_prod = PROD_W'(whole_q) * PROD_W'(RECIP_V);
    back_prod = 32'(quot_q) * DEPTH_V;
    whole_rem = whole_q - back_prod[INT_W-1:0];
    whole_d   = whole_q;
    frac_d    = frac_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    run_d     = 1'b0;
    fin_d     = 1'b0;
    if (start_i) begin
      whole_d = value_i[DELAY_W-1:FRAC_W];
      frac_d  = value_i[FRAC_W-1:0];
      run_d   = 1'b1;
    end else if (run_q) begin
      quot_d = INT_W'(quot_prod >> SHIFT);
      fin_d  = 1'b1;
    end else if (fin_q) begin
      rem_d = {whole_rem, frac_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q <= '0;
      frac_q  <= '0;
      quot_q  <= '0;
      rem_q   <= RESET_MOD;
      run_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      whole_q <= whole_d;
      frac_q  <= frac_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
    end
  end

  assign busy_o  = run_q | fin_q;
  assign delay_o = rem_q;

endmodule

// ----- design/ffdl_ring_mem.sv -----
// Sample ring memory: one write port and two registered read ports.
// Depends on ffdl_pkg.
`timescale 1ns / 1ps

module ffdl_ring_mem #(
  parameter int unsigned DELAY_DEPTH = 65536,
  parameter int unsigned CHANNELS    = 2,
  localparam int unsigned AW = $clog2(DELAY_DEPTH),
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [CW-1:0]     wr_ch_i,
  input  logic [AW-1:0]     wr_idx_i,
  input  ffdl_pkg::sample_t wr_data_i,
  input  logic              rd_en_i,
  input  logic [CW-1:0]     rd_ch_i,
  input  logic [AW-1:0]     rd_idx0_i,
  input  logic [AW-1:0]     rd_idx1_i,
  output ffdl_pkg::sample_t rd_data0_o,
  output ffdl_pkg::sample_t rd_data1_o
);
  import ffdl_pkg::*;

  sample_t mem_q [CHANNELS][DELAY_DEPTH];
  sample_t rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ch_i][wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd0_q <= mem_q[rd_ch_i][rd_idx0_i];
      rd1_q <= mem_q[rd_ch_i][rd_idx1_i];
    end
  end

  assign rd_data0_o = rd0_q;
  assign rd_data1_o = rd1_q;

endmodule

// ----- tb/echo_checker.sv -----
// Checker for the fractional feedback delay line: watches the sample, result and register
// channels, predicts each result from its own copy of the rings and registers, and compares.
// Depends on ffdl_pkg for the register indexes, widths and the reset delay.
`timescale 1ns / 1ps

module echo_checker #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned CHANS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [15:0]                     s_tdata_i,     // [15:0] in_sample
  input  logic                            s_tuser_i,     // [0] channel_index
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [15:0]                     m_tdata_i,     // [15:0] out_sample
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ffdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffdl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import ffdl_pkg::*;

  localparam int unsigned REPORT_MAX = 50;

  logic signed [15:0] echo_ring [CHANS][DEPTH];
  int unsigned        head [CHANS];
  logic [23:0]        delay_reg;
  logic signed [15:0] gain_reg;
  logic signed [15:0] mix_q [$];

  function automatic logic signed [15:0] clamp16(input longint v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Read behind the write pointer, interpolate, then write back the input plus the
  // scaled echo and advance the pointer.
  task automatic mix_echo(input logic ch_raw, input logic [15:0] raw);
    int unsigned       ch;
    longint unsigned   ring_len;
    longint unsigned   dly_fx;
    longint unsigned   pos;
    int unsigned       i0;
    int unsigned       i1;
    int unsigned       frac;
    longint            x;
    longint            s0;
    longint            s1;
    longint            echo;
    longint            fb;
    ch       = int'(ch_raw) % CHANS;
    x        = longint'($signed(raw));
    ring_len = longint'(DEPTH) * 256;
    dly_fx   = longint'(delay_reg) % ring_len;
    pos      = (longint'(head[ch]) * 256 + ring_len - dly_fx) % ring_len;
    i0       = int'(pos >> 8);
    frac     = int'(pos & 255);
    i1       = (i0 + 1 < DEPTH) ? i0 + 1 : 0;
    s0       = longint'(echo_ring[ch][i0]);
    s1       = longint'(echo_ring[ch][i1]);
    echo     = (s0 * 256 + longint'(frac) * (s1 - s0) + 128) >>> 8;
    fb       = (echo * longint'(gain_reg) + 16384) >>> 15;
    echo_ring[ch][head[ch]] = clamp16(x + fb);
    head[ch] = (head[ch] + 1) % DEPTH;
    mix_q.push_back(clamp16(x + echo));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      for (int c = 0; c < CHANS; c++) begin
        for (int i = 0; i < DEPTH; i++) begin
          echo_ring[c][i] = '0;
        end
        head[c] = 0;
      end
      delay_reg    = DELAY_RESET;
      gain_reg     = '0;
      mix_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DELAY_SAMPLES: delay_reg = cfg_data_i[23:0];
          CFG_FEEDBACK_GAIN: gain_reg  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        mix_echo(s_tuser_i, s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (mix_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX) begin
            $error("out_sample: expected none pending, actual %0d", $signed(m_tdata_i));
          end
          fail_count_o++;
        end else begin
          want = mix_q.pop_front();
          checked_o++;
          if (m_tdata_i !== want) begin
            if (fail_count_o < REPORT_MAX) begin
              $error("out_sample: expected %0d, actual %0d", want, $signed(m_tdata_i));
            end
            fail_count_o++;
          end
        end
      end
      pending_o = mix_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the delay line testbench: clock, reset, sample and register stimulus, verdict.
// Depends on ffdl_pkg, the fractional_feedback_delay_line RTL and echo_checker.
`timescale 1ns / 1ps

module tb_top;
  import ffdl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned RING_DEPTH  = 65536;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;
  int unsigned sent [2];
  int unsigned samples_sent;
  int unsigned settings_used;

  fractional_feedback_delay_line uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  echo_checker echo_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
  end

  task automatic set_gaps();
    if (samples_sent < 520) begin
      src_gap_pct  = 21;
      sink_gap_pct = 50;
    end else if (samples_sent < 1040) begin
      src_gap_pct  = 50;
      sink_gap_pct = 21;
    end else begin
      src_gap_pct  = 0;
      sink_gap_pct = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic apply_setting(input logic [23:0] dly, input logic [15:0] gain, input bit spare);
    if (spare) begin
      write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    write_reg(CFG_DELAY_SAMPLES, dly);
    write_reg(CFG_FEEDBACK_GAIN, {8'($urandom_range(3) == 0 ? $urandom : 0), gain});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(input logic ch, input logic [15:0] x);
    logic rdy;
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= ch;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sent[ch] = (sent[ch] + 1) % RING_DEPTH;
    samples_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    case ($urandom_range(9))
      0:       v = 16'h7fff;
      1:       v = 16'h8000;
      2:       v = 16'($signed($urandom_range(128)) - 64);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [23:0] pick_delay();
    logic [23:0] d;
    int unsigned ch;
    ch = $urandom_range(1);
    case ($urandom_range(5))
      0:       d = 24'($urandom_range(255));
      1:       d = 24'($urandom_range(40 * 256));
      2:       d = 24'(sent[ch] * 256 + $urandom_range(1, 256));
      3:       d = 24'($urandom);
      4:       d = $urandom_range(1) ? 24'hffffff : 24'h000000;
      default: d = 24'($urandom_range(8 * 256));
    endcase
    return d;
  endfunction

  function automatic logic [15:0] pick_gain();
    logic [15:0] g;
    case ($urandom_range(4))
      0:       g = 16'h7fff;
      1:       g = 16'h8000;
      2:       g = 16'h0000;
      default: g = 16'($urandom);
    endcase
    return g;
  endfunction

  initial begin
    int unsigned n;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_DELAY_SAMPLES;
    cfg_data_i    <= '0;
    sent[0] = 0;
    sent[1] = 0;
    samples_sent  = 0;
    settings_used = 0;
    set_gaps();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: the long default delay reads unwritten entries.
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b0, 16'h0000);
    send_sample(1'b1, 16'h0001);
    drain();
    // Zero delay reads the oldest entry at the write pointer itself.
    apply_setting(24'h000000, 16'h8000, 1'b1);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b1, 16'h7fff);
    send_sample(1'b0, 16'h1234);
    send_sample(1'b1, 16'hedcb);
    drain();
    // Half a sample with full positive feedback drives the outputs into saturation.
    apply_setting(24'h000080, 16'h7fff, 1'b0);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    drain();
    apply_setting(24'hffffff, 16'h4000, 1'b0);
    send_sample(1'b0, 16'h4000);
    send_sample(1'b1, 16'hc000);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    drain();
    // The read lands on the last ring entry, so the neighbor wraps to entry zero.
    apply_setting(24'(sent[0] * 256 + 64), 16'hffff, 1'b0);
    send_sample(1'b0, 16'h5555);
    send_sample(1'b1, 16'haaaa);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b1, 16'h7fff);
    drain();

    while (samples_sent < ITEM_TARGET) begin
      set_gaps();
      apply_setting(pick_delay(), pick_gain(), $urandom_range(3) == 0);
      n = $urandom_range(80, 160);
      repeat (n) send_sample(1'($urandom_range(1)), pick_sample());
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("Sent %0d samples on both channels under %0d register settings,", samples_sent,
             settings_used);
    $display("with stalls on each stream in turn; %0d results compared, %0d mismatched.",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results still pending.", pending);
    $display("status: fail");
    $finish;
  end

endmodule
